### rtl/csrmv_pkg.sv
package csrmv_pkg;

  localparam int unsigned VectorDepth = 1024;
  localparam int unsigned IdxW        = $clog2(VectorDepth);

  localparam int unsigned ColW  = 10;
  localparam int unsigned NumW  = 32;
  localparam int unsigned RowW  = 10;
  localparam int unsigned AccW  = 64;
  localparam int unsigned FracW = 16;
  localparam int unsigned ActW  = 2;

  localparam int unsigned InTdataW  = ((ColW + NumW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((RowW + NumW + 7) / 8) * 8;

  localparam int unsigned ShW = AccW - FracW;

  typedef enum logic [ActW-1:0] {
    ActLoad    = 2'd0,
    ActNonzero = 2'd1,
    ActClose   = 2'd2
  } action_e;

  typedef struct packed {
    logic vld;
    logic mac;
    logic emit;
  } stage_t;

  // column folded onto the store (depth is a power of two)
  function automatic logic [IdxW-1:0] store_idx(input logic [ColW-1:0] col);
    logic [IdxW+ColW-1:0] wide;
    wide = {{IdxW{1'b0}}, col};
    return wide[IdxW-1:0];
  endfunction

  // Q32.32 to Q16.16, floor then saturate
  function automatic logic [NumW-1:0] sat_q16(input logic [AccW-1:0] acc);
    logic [ShW-1:0] q;
    logic [ShW-NumW:0] top;
    q   = acc[AccW-1:FracW];
    top = q[ShW-1:NumW-1];
    if ((&top) || ~(|top)) begin
      return q[NumW-1:0];
    end else if (q[ShW-1]) begin
      return {1'b1, {(NumW-1){1'b0}}};
    end else begin
      return {1'b0, {(NumW-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/csrmv_ram.sv
module csrmv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/csr_sparse_matrix_vector_multiply.sv
// Sparse matrix times dense vector in compressed-row form, signed Q16.16 in, Q32.32
// wrapping accumulator, saturated Q16.16 row sums out. tuser carries the action (load
// vector entry, nonzero, close empty row), tlast marks the final nonzero of a row. One
// transaction is taken per cycle whenever the output register is free or being drained;
// a row result reaches the output register from the transaction that closes the row
// through the vector store read, the multiplier stage, the accumulator stage and the
// saturating output stage. The vector store needs no clearing after reset; a nonzero
// may follow a load of the same column in the very next cycle.
module csr_sparse_matrix_vector_multiply (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // column [9:0], number [41:10], zero fill above
  input  logic [csrmv_pkg::InTdataW-1:0]      s_axis_tdata,
  // action
  input  logic [csrmv_pkg::ActW-1:0]          s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // row_index [9:0], row_value [41:10], zero fill above
  output logic [csrmv_pkg::OutTdataW-1:0]     m_axis_tdata
);

  localparam int unsigned NumW = csrmv_pkg::NumW;
  localparam int unsigned ColW = csrmv_pkg::ColW;
  localparam int unsigned RowW = csrmv_pkg::RowW;
  localparam int unsigned AccW = csrmv_pkg::AccW;

  logic                 adv;
  logic                 in_acc;
  csrmv_pkg::action_e   act;
  logic [ColW-1:0]      in_col;
  logic [NumW-1:0]      in_num;
  logic [csrmv_pkg::IdxW-1:0] idx;
  logic [NumW-1:0]      vec_rdata;

  csrmv_pkg::stage_t    s1_d, s1_q, s2_q;
  logic signed [NumW-1:0] num1_q;
  logic signed [AccW-1:0] prod_raw;
  logic signed [AccW-1:0] prod_d, prod_q;

  logic [AccW-1:0]      acc_d, acc_q, sum;
  logic [RowW-1:0]      row_d, row_q;
  logic                 s3_vld_q;
  logic [AccW-1:0]      sum3_q;
  logic [RowW-1:0]      row3_q;

  logic                 m_vld_q;
  logic [RowW-1:0]      m_row_q;
  logic [NumW-1:0]      m_val_q;

  assign adv           = !m_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;
  assign act           = csrmv_pkg::action_e'(s_axis_tuser);
  assign in_col        = s_axis_tdata[ColW-1:0];
  assign in_num        = s_axis_tdata[ColW+NumW-1:ColW];
  assign idx           = csrmv_pkg::store_idx(in_col);

  csrmv_ram #(
    .Width (NumW),
    .Depth (csrmv_pkg::VectorDepth)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (act == csrmv_pkg::ActLoad)),
    .waddr_i (idx),
    .wdata_i (in_num),
    .re_i    (in_acc && (act == csrmv_pkg::ActNonzero)),
    .raddr_i (idx),
    .rdata_o (vec_rdata)
  );

  always_comb begin
    s1_d = '0;
    s1_d.vld = in_acc;
    case (act)
      csrmv_pkg::ActNonzero: begin
        s1_d.mac  = 1'b1;
        s1_d.emit = s_axis_tlast;
      end
      csrmv_pkg::ActClose: begin
        s1_d.emit = 1'b1;
      end
      default: begin
        s1_d.vld = 1'b0;
      end
    endcase
    s1_d.vld = s1_d.vld && in_acc;
  end

  assign prod_raw = num1_q * $signed(vec_rdata);
  assign prod_d   = s1_q.mac ? prod_raw : '0;
  assign sum      = acc_q + prod_q;

  always_comb begin
    acc_d = acc_q;
    row_d = row_q;
    if (adv && s2_q.vld) begin
      if (s2_q.emit) begin
        acc_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        acc_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_q     <= '0;
      s3_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
      acc_q    <= '0;
      row_q    <= '0;
    end else begin
      acc_q <= acc_d;
      row_q <= row_d;
      if (adv) begin
        s1_q     <= s1_d;
        s2_q     <= s1_q;
        s3_vld_q <= s2_q.vld && s2_q.emit;
        m_vld_q  <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num1_q  <= in_num;
      prod_q  <= prod_d;
      sum3_q  <= sum;
      row3_q  <= row_q;
      m_row_q <= row3_q;
      m_val_q <= csrmv_pkg::sat_q16(sum3_q);
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {{(csrmv_pkg::OutTdataW - RowW - NumW){1'b0}}, m_val_q, m_row_q};

`ifndef ASSERT_OFF
  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output register");

  a_acc_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_q.vld && s2_q.emit) |=> (acc_q == '0))
    else $error("accumulator not cleared after row close");

  a_row_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_q.vld && s2_q.emit) |=> (row_q == $past(row_q) + RowW'(1)))
    else $error("row counter did not advance on row close");

  a_row_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && s2_q.vld && s2_q.emit) |=> $stable(row_q))
    else $error("row counter moved without a row close");
`endif

endmodule

### dv/csr_sparse_matrix_vector_multiply_tb.sv
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_tb;

  localparam int unsigned ActW        = csrmv_pkg::ActW;
  localparam int unsigned ColW        = csrmv_pkg::ColW;
  localparam int unsigned NumW        = csrmv_pkg::NumW;
  localparam int unsigned RowW        = csrmv_pkg::RowW;
  localparam int unsigned AccW        = csrmv_pkg::AccW;
  localparam int unsigned FracW       = csrmv_pkg::FracW;
  localparam int unsigned VectorDepth = csrmv_pkg::VectorDepth;
  localparam int unsigned InTdataW    = csrmv_pkg::InTdataW;
  localparam int unsigned OutTdataW   = csrmv_pkg::OutTdataW;

  localparam logic [ActW-1:0] ActLoad    = csrmv_pkg::ActLoad;
  localparam logic [ActW-1:0] ActNonzero = csrmv_pkg::ActNonzero;
  localparam logic [ActW-1:0] ActClose   = csrmv_pkg::ActClose;
  localparam logic [ActW-1:0] ActUnused = 2'd3;
  localparam int unsigned NumRandom = 200;
  localparam int unsigned RowTarget = 1030;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 12;

  typedef struct packed {
    logic            drain;
    logic [ActW-1:0] act;
    logic [ColW-1:0] col;
    logic [NumW-1:0] num;
    logic            last;
  } spmv_item_t;

  typedef struct packed {
    logic [RowW-1:0] idx;
    logic [NumW-1:0] val;
  } row_sum_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [ActW-1:0]      s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  spmv_item_t pending_items[$];
  row_sum_t   pending_row_sums[$];

  // predictor state
  logic [NumW-1:0] x_copy [VectorDepth];
  logic [AccW-1:0] row_acc = '0;
  logic [RowW-1:0] row_num = '0;

  int unsigned n_sent = 0;
  int unsigned n_acc = 0;
  int unsigned n_rows_seen = 0;
  int unsigned n_errors = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  csr_sparse_matrix_vector_multiply dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [NumW-1:0] q16_of_acc(input logic [AccW-1:0] acc);
    logic signed [AccW-1:0] q;
    q = $signed(acc) >>> FracW;
    if (q > 64'sh7FFFFFFF) begin
      return 32'h7FFFFFFF;
    end else if (q < -64'sh80000000) begin
      return 32'h80000000;
    end
    return q[NumW-1:0];
  endfunction

  task automatic close_row();
    row_sum_t r;
    r.idx = row_num;
    r.val = q16_of_acc(row_acc);
    pending_row_sums.push_back(r);
    row_acc = '0;
    row_num = row_num + 1'b1;
  endtask

  task automatic spmv_step(input logic [ActW-1:0] act, input logic [ColW-1:0] col,
                           input logic [NumW-1:0] num, input logic last);
    logic signed [AccW-1:0] a;
    logic signed [AccW-1:0] b;
    a = $signed(num);
    b = $signed(x_copy[col]);
    case (act)
      ActLoad: begin
        x_copy[col] = num;
      end
      ActNonzero: begin
        row_acc = row_acc + (a * b);
        if (last) begin
          close_row();
        end
      end
      ActClose: begin
        close_row();
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [NumW-1:0] got,
                                 input logic [NumW-1:0] want);
    n_errors++;
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
  endtask

  // stimulus driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || n_acc == n_sent) begin
        if (pending_items.size() != 0 && pending_items[0].drain) begin
          if (pending_row_sums.size() == 0) begin
            pending_items.delete(0);
          end
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     ((n_sent >= 600 && n_sent < 800) || $urandom_range(99) >= 8)) begin
          s_axis_tdata  <= {{(InTdataW-ColW-NumW){1'b0}}, pending_items[0].num,
                            pending_items[0].col};
          s_axis_tuser  <= pending_items[0].act;
          s_axis_tlast  <= pending_items[0].last;
          s_axis_tvalid <= 1'b1;
          n_sent        <= n_sent + 1;
          pending_items.delete(0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      spmv_step(s_axis_tuser, s_axis_tdata[ColW-1:0], s_axis_tdata[ColW+NumW-1:ColW],
                s_axis_tlast);
      n_acc <= n_acc + 1;
    end
  end

  // result sink, with one long hold-off once traffic is flowing
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_rows_seen >= 60) begin
        hold_left     <= HoldCycles;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (n_rows_seen >= 300 && n_rows_seen < 420) ||
                         ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin : check_rows
    row_sum_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_row_sums.size() == 0) begin
        report_mismatch("unexpected row result", m_axis_tdata[NumW-1:0], '0);
      end else begin
        want = pending_row_sums.pop_front();
        if (m_axis_tdata[RowW-1:0] != want.idx) begin
          report_mismatch("row_index", NumW'(m_axis_tdata[RowW-1:0]), NumW'(want.idx));
        end
        if (m_axis_tdata[RowW+NumW-1:RowW] != want.val) begin
          report_mismatch("row_value", m_axis_tdata[RowW+NumW-1:RowW], want.val);
        end
      end
      n_rows_seen <= n_rows_seen + 1;
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  bit          loaded [VectorDepth];
  int unsigned loaded_cols[$];
  int unsigned rows_queued = 0;

  task automatic queue_item(input logic [ActW-1:0] act, input logic [ColW-1:0] col,
                            input logic [NumW-1:0] num, input logic last);
    spmv_item_t it;
    it.drain = 1'b0;
    it.act   = act;
    it.col   = col;
    it.num   = num;
    it.last  = last;
    pending_items.push_back(it);
    if (act == ActLoad && !loaded[col]) begin
      loaded[col] = 1'b1;
      loaded_cols.push_back(col);
    end
    if (act == ActClose || (act == ActNonzero && last)) begin
      rows_queued++;
    end
  endtask

  task automatic queue_drain();
    spmv_item_t it;
    it = '0;
    it.drain = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [NumW-1:0] pick_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      return $urandom;
    end else if (r < 90) begin
      return 32'(int'($urandom_range(2097151)) - 1048576);
    end else if (r < 95) begin
      return 32'h7FFFFFFF;
    end
    return 32'h80000000;
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned r;

    // directed: extremes, saturation, rounding, ignored flags, wrap, back-to-back
    queue_item(ActLoad, 10'd0, 32'h7FFFFFFF, 1'b1);
    queue_item(ActLoad, 10'd1023, 32'h80000000, 1'b0);
    queue_item(ActLoad, 10'd1, 32'h00010000, 1'b0);
    queue_item(ActLoad, 10'd2, 32'hFFFF0000, 1'b0);
    queue_item(ActClose, 10'd0, 32'h0, 1'b0);
    queue_item(ActNonzero, 10'd0, 32'h7FFFFFFF, 1'b1);
    queue_item(ActNonzero, 10'd1023, 32'h80000000, 1'b1);
    queue_item(ActNonzero, 10'd0, 32'h80000000, 1'b1);
    queue_item(ActNonzero, 10'd1, 32'h00018000, 1'b1);
    queue_item(ActNonzero, 10'd2, 32'h00000001, 1'b1);
    queue_item(ActNonzero, 10'd1, 32'h00030000, 1'b0);
    queue_item(ActClose, 10'd1023, 32'hFFFFFFFF, 1'b1);
    queue_item(ActUnused, 10'd1023, 32'hFFFFFFFF, 1'b1);
    repeat (3) queue_item(ActNonzero, 10'd1023, 32'h80000000, 1'b0);
    queue_item(ActNonzero, 10'd1023, 32'h80000000, 1'b1);
    queue_item(ActLoad, 10'd5, 32'h00020000, 1'b0);
    queue_item(ActNonzero, 10'd5, 32'h00020000, 1'b1);
    queue_drain();

    n = 0;
    while (n < NumRandom) begin
      r = $urandom_range(99);
      if (r < 12) begin
        queue_item(ActLoad, 10'($urandom_range(1023)), pick_number(), 1'($urandom));
      end else if (r < 20) begin
        queue_item(ActClose, 10'($urandom), $urandom, 1'($urandom));
      end else if (r < 23) begin
        queue_item(ActUnused, 10'($urandom), $urandom, 1'($urandom));
        continue;
      end else begin
        queue_item(ActNonzero, 10'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]),
                   pick_number(), ($urandom_range(2) == 0));
      end
      n++;
      if (n == NumRandom / 2) begin
        queue_drain();
      end
    end
    // carry the row counter through its wrap with short rows
    while (rows_queued < RowTarget) begin
      if ($urandom_range(1) == 0) begin
        queue_item(ActNonzero, 10'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]),
                   pick_number(), 1'b1);
      end else begin
        queue_item(ActClose, 10'($urandom), $urandom, 1'($urandom));
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || (s_axis_tvalid && n_acc != n_sent)) begin
      @(negedge clk_i);
    end
    while (pending_row_sums.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(negedge clk_i);

    $display("Run: %0d transactions in, %0d row sums out, %0d distinct vector entries loaded",
             n_acc, n_rows_seen, loaded_cols.size());
    $display("Row counter wrapped %0d time(s); %0d mismatch(es)",
             n_rows_seen / (1 << RowW), n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/csrmv_pkg.sv
rtl/csrmv_ram.sv
rtl/csr_sparse_matrix_vector_multiply.sv
dv/csr_sparse_matrix_vector_multiply_tb.sv
